>>> hdl/rfdr_pkg.sv
// Package for the record FIFO: sizes, codes, state encoding and the store write struct.
// No dependencies; every other file in hdl/ imports it.
package rfdr_pkg;

   localparam int MAX_RECORD_BYTES = 64;
   localparam int SLOT_COUNT       = 1024;
   localparam int CAPACITY_RESET   = 1000;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int CAP_W       = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int OFS_W       = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int BYTE_ADDR_W = SLOT_W + OFS_W;
   localparam int BYTE_DEPTH  = SLOT_COUNT * (2 ** OFS_W);
   localparam int CNT_W       = (SLOT_W + 1 > CAP_W) ? SLOT_W + 1 : CAP_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_TOO_LARGE,
      STATUS_FULL,
      STATUS_EMPTY
   } status_type;

   typedef enum logic {
      KIND_PUSH_ACK,
      KIND_POP_BEAT
   } reply_kind_type;

   typedef enum logic {
      ACTION_PUSH,
      ACTION_POP
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OVERFLOW_MODE,
      CSR_CAPACITY
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN_RD,
      ST_LEN_CHK,
      ST_BYTE_RD,
      ST_BYTE_OUT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                   byte_we;
      logic [BYTE_ADDR_W-1:0] byte_addr;
      logic [BYTE_W-1:0]      byte_data;
      logic                   len_we;
      logic [SLOT_W-1:0]      len_addr;
      logic [LEN_W-1:0]       len_data;
   } store_wr_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (s == SLOT_W'(SLOT_COUNT - 1)) begin
         n = '0;
      end else begin
         n = s + 1'b1;
      end
      return n;
   endfunction

endpackage

>>> hdl/rfdr_req_if.sv
// Request channel interface: valid/ready handshake plus one push or pop beat.
// Depends on rfdr_pkg for field widths.
interface rfdr_req_if;
   import rfdr_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic              has_byte;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_record;

   modport source (output valid, action, has_byte, data_byte, end_of_record, input ready);
   modport sink   (input valid, action, has_byte, data_byte, end_of_record, output ready);
endinterface

>>> hdl/rfdr_rsp_if.sv
// Response channel interface: valid/ready handshake plus one reply beat.
// Depends on rfdr_pkg for field widths.
interface rfdr_rsp_if;
   import rfdr_pkg::*;

   logic                valid;
   logic                ready;
   logic                reply_kind;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   out_byte;
   logic [LEN_W-1:0]    record_length;
   logic                last_beat;

   modport source (output valid, reply_kind, status, out_byte, record_length, last_beat,
                   input ready);
   modport sink   (input valid, reply_kind, status, out_byte, record_length, last_beat,
                   output ready);
endinterface

>>> hdl/rfdr_store.sv
// Record storage: slot byte memory and slot length memory, registered reads.
// Depends on rfdr_pkg; contents are not cleared by reset.
module rfdr_store (
   input  logic                            clock,
   input  rfdr_pkg::store_wr_type          wr,
   input  logic [rfdr_pkg::BYTE_ADDR_W-1:0] byte_raddr,
   output logic [rfdr_pkg::BYTE_W-1:0]     byte_rdata,
   input  logic [rfdr_pkg::SLOT_W-1:0]     len_raddr,
   output logic [rfdr_pkg::LEN_W-1:0]      len_rdata
);
   import rfdr_pkg::*;

   logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];
   logic [LEN_W-1:0]  len_mem  [SLOT_COUNT];
   logic [BYTE_W-1:0] byte_rdata_ff;
   logic [LEN_W-1:0]  len_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         byte_mem[wr.byte_addr] <= wr.byte_data;
      end
      byte_rdata_ff <= byte_mem[byte_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr.len_addr] <= wr.len_data;
      end
      len_rdata_ff <= len_mem[len_raddr];
   end

   assign byte_rdata = byte_rdata_ff;
   assign len_rdata  = len_rdata_ff;

endmodule

>>> hdl/record_fifo_drop_or_reject_top.sv
// Record FIFO top level: push/pop sequencer, slot pointers, counters and config registers.
// Depends on rfdr_pkg, rfdr_req_if, rfdr_rsp_if and rfdr_store.
// Push beat that does not end a record: taken in ST_IDLE, which stays ready for the next beat.
// Push beat that ends a record: acknowledgement valid in the next cycle; ready after it leaves.
// Pop: ST_LEN_RD, ST_LEN_CHK, ST_BYTE_RD, then the first byte in ST_BYTE_OUT; later bytes each repeat
// ST_BYTE_RD (registered byte read) and wait on the sink; empty pop answers in the next cycle.
// Reset (synchronous): pointers, counts and partial-record state clear, overflow_mode 0,
// capacity 1000; the slot memories are not cleared and need no clearing pass.
module record_fifo_drop_or_reject_top (
   input  logic                            clock,
   input  logic                            reset,
   rfdr_req_if.sink                        req_if,
   rfdr_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [rfdr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfdr_pkg::CSR_DATA_W-1:0] csr_data
);
   import rfdr_pkg::*;

   // Sequencer state
   state_type state_ff, state_in;

   // Queue bookkeeping
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  bic_ff, bic_in;      // bytes in the record being pushed
   logic              ovs_ff, ovs_in;      // oversize seen on the record being pushed

   // Pop walk
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [OFS_W-1:0]  idx_ff, idx_in;

   // Single-beat reply holding register (acks, empty replies, empty records)
   reply_kind_type    kind_ff, kind_in;
   status_type        status_ff, status_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;

   // Configuration registers
   logic              mode_ff;
   logic [CAP_W-1:0]  cap_ff;

   // Store interface
   store_wr_type      store_wr;
   logic [BYTE_W-1:0] byte_rdata;
   logic [LEN_W-1:0]  len_rdata;

   // Shared helpers
   logic              req_fire;
   logic              rsp_fire;
   logic [CNT_W-1:0]  cap_x;
   logic [CNT_W-1:0]  eff_cap;
   logic              full;
   logic [LEN_W-1:0]  len_clamp;
   logic              beat_last;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   // Clamp capacity into 1 .. SLOT_COUNT-1 so the tail slot never holds a live record.
   assign cap_x = CNT_W'(cap_ff);
   always_comb begin
      if (cap_x == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_x > CNT_W'(SLOT_COUNT - 1)) begin
         eff_cap = CNT_W'(SLOT_COUNT - 1);
      end else begin
         eff_cap = cap_x;
      end
   end
   assign full = (count_ff >= eff_cap);

   assign len_clamp = (len_rdata > LEN_W'(MAX_RECORD_BYTES)) ?
                      LEN_W'(MAX_RECORD_BYTES) : len_rdata;
   assign beat_last = ((LEN_W'(idx_ff) + 1'b1) == len_ff);

   rfdr_store u_store (
      .clock      (clock),
      .wr         (store_wr),
      .byte_raddr ({head_ff, idx_ff}),
      .byte_rdata (byte_rdata),
      .len_raddr  (head_ff),
      .len_rdata  (len_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.action == ACTION_POP) begin
                  state_in = (count_ff == '0) ? ST_RESP : ST_LEN_RD;
               end else if (req_if.end_of_record) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_LEN_RD: begin
            state_in = ST_LEN_CHK;
         end
         ST_LEN_CHK: begin
            state_in = (len_clamp == '0) ? ST_RESP : ST_BYTE_RD;
         end
         ST_BYTE_RD: begin
            state_in = ST_BYTE_OUT;
         end
         ST_BYTE_OUT: begin
            if (rsp_fire) begin
               state_in = beat_last ? ST_IDLE : ST_BYTE_RD;
            end
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Channel outputs: byte beats come straight from the registered memory read.
   always_comb begin
      req_if.ready         = (state_ff == ST_IDLE);
      rsp_if.valid         = 1'b0;
      rsp_if.reply_kind    = kind_ff;
      rsp_if.status        = status_ff;
      rsp_if.out_byte      = '0;
      rsp_if.record_length = rlen_ff;
      rsp_if.last_beat     = 1'b1;
      unique case (state_ff)
         ST_RESP: begin
            rsp_if.valid = 1'b1;
         end
         ST_BYTE_OUT: begin
            rsp_if.valid         = 1'b1;
            rsp_if.reply_kind    = KIND_POP_BEAT;
            rsp_if.status        = STATUS_OK;
            rsp_if.out_byte      = byte_rdata;
            rsp_if.record_length = len_ff;
            rsp_if.last_beat     = beat_last;
         end
         default: begin
            rsp_if.valid = 1'b0;
         end
      endcase
   end

   // Datapath next values and store writes
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      bic_in    = bic_ff;
      ovs_in    = ovs_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      rlen_in   = rlen_ff;

      store_wr.byte_we   = 1'b0;
      store_wr.byte_addr = {tail_ff, bic_ff[OFS_W-1:0]};
      store_wr.byte_data = req_if.data_byte;
      store_wr.len_we    = 1'b0;
      store_wr.len_addr  = tail_ff;
      store_wr.len_data  = bic_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_if.action == ACTION_PUSH) begin
               // Store the byte while there is room, else flag the record oversize.
               if (req_if.has_byte) begin
                  if (bic_ff < LEN_W'(MAX_RECORD_BYTES)) begin
                     store_wr.byte_we = 1'b1;
                     bic_in           = bic_ff + 1'b1;
                  end else begin
                     ovs_in = 1'b1;
                  end
               end
               if (req_if.end_of_record) begin
                  kind_in = KIND_PUSH_ACK;
                  rlen_in = '0;
                  if (ovs_in) begin
                     status_in = STATUS_TOO_LARGE;
                  end else if (full && mode_ff) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in         = STATUS_OK;
                     rlen_in           = bic_in;
                     store_wr.len_we   = 1'b1;
                     store_wr.len_data = bic_in;
                     tail_in           = next_slot(tail_ff);
                     // Drop the oldest to make room; the count then stays put.
                     if (full) begin
                        head_in = next_slot(head_ff);
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bic_in = '0;
                  ovs_in = 1'b0;
               end
            end else if (req_fire && count_ff == '0) begin
               kind_in   = KIND_POP_BEAT;
               status_in = STATUS_EMPTY;
               rlen_in   = '0;
            end
         end
         ST_LEN_CHK: begin
            len_in = len_clamp;
            idx_in = '0;
            if (len_clamp == '0) begin
               // Empty record: retire the slot now, then send one beat from the reply register.
               kind_in   = KIND_POP_BEAT;
               status_in = STATUS_OK;
               rlen_in   = '0;
               head_in   = next_slot(head_ff);
               count_in  = count_ff - 1'b1;
            end
         end
         ST_BYTE_OUT: begin
            if (rsp_fire) begin
               if (beat_last) begin
                  head_in  = next_slot(head_ff);
                  count_in = count_ff - 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         bic_ff   <= '0;
         ovs_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         bic_ff   <= bic_in;
         ovs_ff   <= ovs_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      rlen_ff   <= rlen_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cap_ff  <= CAP_W'(CAPACITY_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OVERFLOW_MODE: mode_ff <= csr_data[0];
            CSR_CAPACITY:      cap_ff  <= csr_data[CAP_W-1:0];
            default:           mode_ff <= mode_ff;
         endcase
      end
   end

`ifndef SYNTH
   logic [CNT_W-1:0] occupancy;
   assign occupancy = (tail_ff >= head_ff) ?
                      CNT_W'(tail_ff - head_ff) :
                      CNT_W'(tail_ff) + CNT_W'(SLOT_COUNT) - CNT_W'(head_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOT_COUNT - 1))
      else $error("record count beyond slot count");

   a_count_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == occupancy)
      else $error("record count disagrees with head and tail");

   a_partial_bound: assert property (@(posedge clock) disable iff (reset)
      bic_ff <= LEN_W'(MAX_RECORD_BYTES))
      else $error("partial record byte count overflow");

   a_no_accept_while_replying: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a reply beat is pending");

   a_pop_retires_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTE_OUT && rsp_fire && beat_last) |=>
      (count_ff == $past(count_ff) - 1'b1 && state_ff == ST_IDLE))
      else $error("last pop beat did not retire exactly one record");
`endif

endmodule

>>> tb/sv/record_fifo_drop_or_reject_top_test.sv
// Self-checking bench for the record FIFO with drop-oldest / reject-new overflow.
// Needs rfdr_pkg, rfdr_req_if, rfdr_rsp_if, record_fifo_drop_or_reject_top and rfdr_store from hdl/.
// A queue-fed driver and a checking monitor run against a cycle-free predictor of the FIFO.
module record_fifo_drop_or_reject_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rfdr_pkg::*;

   typedef struct {
      action_type        action;
      logic              has_byte;
      logic [BYTE_W-1:0] data;
      logic              end_of_record;
   } fifo_req_type;

   typedef struct {
      reply_kind_type    kind;
      status_type        status;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  rec_len;
      logic              last_beat;
   } fifo_reply_type;

   // Longest quiet spell the block may still need after its last reply or last
   // non-ending push beat.
   localparam int IDLE_PAUSE  = 16;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 24;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   rfdr_req_if req_bus ();
   rfdr_rsp_if rsp_bus ();

   record_fifo_drop_or_reject_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the slot store, pointers, partial
   // record tracking and the two registers.
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0] slot_data [SLOT_COUNT][MAX_RECORD_BYTES];
   logic [LEN_W-1:0]  slot_len  [SLOT_COUNT];
   int                head_idx     = 0;
   int                tail_idx     = 0;
   int                live_records = 0;
   int                fill_bytes   = 0;
   bit                too_long     = 1'b0;
   bit                mode_reg     = 1'b0;
   int                cap_reg      = CAPACITY_RESET;

   fifo_req_type   req_backlog [$];
   fifo_reply_type awaited_replies [$];
   fifo_req_type   req_cur = '{ACTION_PUSH, 1'b0, '0, 1'b0};

   bit req_busy  = 1'b0;
   int req_gap   = 0;
   int rsp_wait  = 0;
   bit no_idle   = 1'b0;
   int items_queued = 0;

   int mismatches    = 0;
   int beats_checked = 0;
   int commits       = 0;
   int drops         = 0;
   int rejects       = 0;
   int oversized     = 0;
   int pops_done     = 0;
   int empty_pops    = 0;

   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 3));
   endfunction

   // Work out the replies one accepted request beat causes and queue them.
   function automatic void predict_replies(input fifo_req_type it);
      fifo_reply_type r;
      int             eff_cap;
      int             n;
      int             i;
      eff_cap = (cap_reg < 1) ? 1 : ((cap_reg > SLOT_COUNT - 1) ? SLOT_COUNT - 1 : cap_reg);
      r.data  = '0;
      if (it.action == ACTION_PUSH) begin
         if (it.has_byte) begin
            if (fill_bytes < MAX_RECORD_BYTES) begin
               slot_data[tail_idx][fill_bytes] = it.data;
               fill_bytes++;
            end else begin
               too_long = 1'b1;
            end
         end
         if (it.end_of_record) begin
            r.kind      = KIND_PUSH_ACK;
            r.rec_len   = '0;
            r.last_beat = 1'b1;
            if (too_long) begin
               r.status = STATUS_TOO_LARGE;
               oversized++;
            end else if (live_records >= eff_cap && mode_reg) begin
               r.status = STATUS_FULL;
               rejects++;
            end else begin
               // drop the oldest record to make room when full
               if (live_records >= eff_cap && live_records > 0) begin
                  head_idx = (head_idx + 1) % SLOT_COUNT;
                  live_records--;
                  drops++;
               end
               slot_len[tail_idx] = LEN_W'(fill_bytes);
               tail_idx           = (tail_idx + 1) % SLOT_COUNT;
               live_records++;
               r.status  = STATUS_OK;
               r.rec_len = LEN_W'(fill_bytes);
               commits++;
            end
            fill_bytes = 0;
            too_long   = 1'b0;
            awaited_replies.push_back(r);
         end
      end else begin
         r.kind = KIND_POP_BEAT;
         if (live_records == 0) begin
            r.status    = STATUS_EMPTY;
            r.rec_len   = '0;
            r.last_beat = 1'b1;
            awaited_replies.push_back(r);
            empty_pops++;
         end else begin
            n         = int'(slot_len[head_idx]);
            r.status  = STATUS_OK;
            r.rec_len = LEN_W'(n);
            if (n == 0) begin
               r.last_beat = 1'b1;
               awaited_replies.push_back(r);
            end else begin
               for (i = 0; i < n; i++) begin
                  r.data      = slot_data[head_idx][i];
                  r.last_beat = (i == n - 1);
                  awaited_replies.push_back(r);
               end
            end
            head_idx = (head_idx + 1) % SLOT_COUNT;
            live_records--;
            pops_done++;
         end
      end
   endfunction

   // Compare the reply beat on the bus with the oldest awaited one.
   function automatic void check_reply();
      fifo_reply_type e;
      if (awaited_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected reply beat kind=%0d status=%0d byte=%02h len=%0d last=%0d",
                     $realtime, rsp_bus.reply_kind, rsp_bus.status, rsp_bus.out_byte,
                     rsp_bus.record_length, rsp_bus.last_beat);
      end else begin
         e = awaited_replies.pop_front();
         beats_checked++;
         if (rsp_bus.reply_kind !== e.kind || rsp_bus.status !== e.status ||
             rsp_bus.out_byte !== e.data || rsp_bus.record_length !== e.rec_len ||
             rsp_bus.last_beat !== e.last_beat) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: reply beat %0d mismatch", $realtime, beats_checked);
               $display("   expected kind=%0d status=%0d byte=%02h len=%0d last=%0d",
                        e.kind, e.status, e.data, e.rec_len, e.last_beat);
               $display("   actual   kind=%0d status=%0d byte=%02h len=%0d last=%0d",
                        rsp_bus.reply_kind, rsp_bus.status, rsp_bus.out_byte,
                        rsp_bus.record_length, rsp_bus.last_beat);
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: present backlog items one beat at a time, predict on
   // acceptance, then hold off for a random number of cycles.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_busy = 1'b0;
         req_gap  = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_replies(req_cur);
            req_busy = 1'b0;
            req_gap  = draw_gap();
         end
         if (!req_busy) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (req_backlog.size() != 0) begin
               req_cur  = req_backlog.pop_front();
               req_busy = 1'b1;
            end
         end
         // one assignment per signal per edge keeps back-to-back beats clean
         req_bus.valid         <= req_busy;
         req_bus.action        <= req_cur.action;
         req_bus.has_byte      <= req_cur.has_byte;
         req_bus.data_byte     <= req_cur.data;
         req_bus.end_of_record <= req_cur.end_of_record;
      end
   end

   // ---------------------------------------------------------------------
   // Reply monitor: check every accepted beat, then stall ready for a
   // random number of cycles before the next one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_reply();
            rsp_wait = draw_gap();
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_bus.ready <= (rsp_wait == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void add_push(input logic has, input logic [BYTE_W-1:0] d,
                                    input logic eor);
      fifo_req_type it;
      it.action        = ACTION_PUSH;
      it.has_byte      = has;
      it.data          = d;
      it.end_of_record = eor;
      req_backlog.push_back(it);
      items_queued++;
   endfunction

   // Payload fields of a pop are don't-care: fill them at random.
   function automatic void add_pop();
      fifo_req_type it;
      it.action        = ACTION_POP;
      it.has_byte      = 1'($urandom_range(0, 1));
      it.data          = BYTE_W'($urandom);
      it.end_of_record = 1'($urandom_range(0, 1));
      req_backlog.push_back(it);
      items_queued++;
   endfunction

   // Queue one record of n bytes; end it on the last byte or with an empty
   // end marker. When mixed, sprinkle pops and byte-less beats inside it.
   function automatic void add_record(input int n, input bit mixed);
      bit eor_on_byte;
      int i;
      eor_on_byte = (n > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < n; i++) begin
         if (mixed && $urandom_range(0, 99) < 8) add_pop();
         if (mixed && $urandom_range(0, 99) < 5) add_push(1'b0, BYTE_W'($urandom), 1'b0);
         add_push(1'b1, BYTE_W'($urandom), eor_on_byte && (i == n - 1));
      end
      if (!eor_on_byte) add_push(1'b0, BYTE_W'($urandom), 1'b1);
   endfunction

   // Mostly short records, now and then one near or past the slot size,
   // plus single pops and pop bursts.
   function automatic void fill_random(input int target);
      int start;
      int pick;
      start = items_queued;
      while (items_queued - start < target) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 50) begin
            if ($urandom_range(0, 99) < 8)
               add_record(int'($urandom_range(MAX_RECORD_BYTES - 4, MAX_RECORD_BYTES + 4)),
                          1'b1);
            else
               add_record(int'($urandom_range(0, 8)), 1'b1);
         end else if (pick < 90) begin
            add_pop();
         end else begin
            repeat ($urandom_range(2, 3)) add_pop();
         end
      end
   endfunction

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_OVERFLOW_MODE) mode_reg = value[0];
      else cap_reg = value & 'h7FF;
   endtask

   // Wait until the backlog is sent and every awaited reply is in, then
   // let the block settle before touching the registers.
   task automatic drain();
      while (req_backlog.size() != 0 || req_busy || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int phase_mode [PHASE_COUNT];
      int phase_cap  [PHASE_COUNT];
      int p;
      phase_mode = '{0, 1, 0, 1, 1, 0, 1, 0};
      phase_cap  = '{2, 3, 2047, 1023, 1, 5, 1024, 4};

      req_bus.valid         = 1'b0;
      req_bus.action        = 1'b0;
      req_bus.has_byte      = 1'b0;
      req_bus.data_byte     = '0;
      req_bus.end_of_record = 1'b0;
      rsp_bus.ready         = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: basics at the default setting. Pop an empty queue, push and
      // pop an empty record, a record ended on a real byte, one ended by a
      // byte-less marker, and a pop that lands in the middle of a push.
      write_csr(CSR_OVERFLOW_MODE, 0);
      write_csr(CSR_CAPACITY, CAPACITY_RESET);
      add_pop();
      add_push(1'b0, 8'h00, 1'b1);
      add_pop();
      add_push(1'b1, 8'h00, 1'b0);
      add_push(1'b1, 8'hFF, 1'b0);
      add_push(1'b0, 8'h3C, 1'b0);
      add_push(1'b1, 8'hA5, 1'b1);
      add_push(1'b1, 8'h5A, 1'b0);
      add_push(1'b0, 8'hC3, 1'b1);
      add_push(1'b1, 8'h81, 1'b0);
      add_pop();
      add_push(1'b1, 8'h7E, 1'b1);
      add_pop();
      add_pop();
      add_pop();
      drain();

      // Directed: capacity zero acts as one; drop mode loses the oldest record.
      write_csr(CSR_CAPACITY, 0);
      add_push(1'b1, 8'h11, 1'b1);
      add_push(1'b1, 8'h22, 1'b1);
      add_pop();
      add_pop();
      drain();

      // Directed: reject mode at capacity one refuses the second record, and an
      // oversized record reports too-large even though the queue is full.
      write_csr(CSR_OVERFLOW_MODE, 1);
      write_csr(CSR_CAPACITY, 1);
      add_push(1'b1, 8'h33, 1'b1);
      add_push(1'b1, 8'h44, 1'b1);
      add_record(MAX_RECORD_BYTES + 1, 1'b0);
      add_pop();
      add_record(MAX_RECORD_BYTES, 1'b0);
      add_pop();
      drain();

      // Random phases over a spread of settings; two of them run without idling.
      for (p = 0; p < PHASE_COUNT; p++) begin
         write_csr(CSR_OVERFLOW_MODE, phase_mode[p]);
         write_csr(CSR_CAPACITY, phase_cap[p]);
         no_idle = (p == 2 || p == 5);
         fill_random(PHASE_ITEMS);
         drain();
      end
      no_idle = 1'b0;

      $display("Run covered %0d request beats: %0d records committed, %0d dropped, %0d rejected",
               items_queued, commits, drops, rejects);
      $display("full, %0d too large; %0d records popped, %0d empty pops, %0d reply beats checked.",
               oversized, pops_done, empty_pops, beats_checked);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d replies missing", mismatches, awaited_replies.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: end the run if the traffic stalls.
   initial begin
      #20_000_000;
      $display("Timeout with %0d replies still awaited", awaited_replies.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
